// ----- hdl/ordered_array_list_engine_defines.svh -----
// Assertion macros shared by the list engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OALE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine assertion failed");

// Next-cycle implication, disabled during reset
`define OALE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine assertion failed");

`endif

// ----- hdl/oale_pkg.sv -----
// Types, codes and microcode table of the ordered array list engine.
// No dependencies; used by oale_seq and ordered_array_list_engine.
`default_nettype none

package oale_pkg;

   // Request kinds
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_DISPATCH,
      STEP_INS_INIT,
      STEP_INS_LOOP,
      STEP_INS_PUT,
      STEP_REM_INIT,
      STEP_REM_LOOP,
      STEP_REM_DONE,
      STEP_SRCH_INIT,
      STEP_SRCH_LOOP,
      STEP_RSP_OK,
      STEP_RSP_HIT,
      STEP_RSP_MISS,
      STEP_RSP_BAD,
      STEP_RSP_FULL
   } step_type;

   typedef enum logic [2:0] {
      PTR_HOLD, PTR_COUNT, PTR_POS1, PTR_ZERO, PTR_INC, PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      RD_NONE, RD_PTR, RD_PTR_M1
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE, WR_SHIFT_UP, WR_SHIFT_DOWN, WR_VALUE
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD, CNT_INC, CNT_DEC
   } cnt_op_type;

   typedef enum logic [2:0] {
      STAY_NONE, STAY_NO_REQ, STAY_MORE_DOWN, STAY_MORE_UP, STAY_RSP_BUSY
   } stay_sel_type;

   typedef enum logic [1:0] {
      JMP_NONE, JMP_MATCH, JMP_DISPATCH
   } jump_sel_type;

   // One control word of the sequencer program
   typedef struct packed {
      logic         req_take;
      ptr_op_type   ptr_op;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      cnt_op_type   cnt_op;
      stay_sel_type stay_sel;
      jump_sel_type jump_sel;
      step_type     target;
      step_type     next_step;
      logic         rsp_load;
      status_type   rsp_status;
      logic         rsp_hit;
   } ucode_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic       req_valid;
      logic       more_down;
      logic       more_up;
      logic       rsp_busy;
      logic       match;
      logic [1:0] kind;
      logic       pos_gt_count;
      logic       pos_ge_count;
      logic       full;
   } seq_cond_type;

   // Gated controls driven into the datapath
   typedef struct packed {
      logic       req_ready;
      ptr_op_type ptr_op;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_hit;
   } seq_ctrl_type;

   // Microcode table: one control word per step
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      w.req_take   = 1'b0;
      w.ptr_op     = PTR_HOLD;
      w.rd_sel     = RD_NONE;
      w.wr_sel     = WR_NONE;
      w.cnt_op     = CNT_HOLD;
      w.stay_sel   = STAY_NONE;
      w.jump_sel   = JMP_NONE;
      w.target     = STEP_IDLE;
      w.next_step  = STEP_IDLE;
      w.rsp_load   = 1'b0;
      w.rsp_status = ST_OK;
      w.rsp_hit    = 1'b0;
      case (step)
         STEP_IDLE: begin
            w.req_take  = 1'b1;
            w.stay_sel  = STAY_NO_REQ;
            w.next_step = STEP_DISPATCH;
         end
         STEP_DISPATCH: begin
            w.jump_sel = JMP_DISPATCH;
         end
         STEP_INS_INIT: begin
            w.ptr_op    = PTR_COUNT;
            w.next_step = STEP_INS_LOOP;
         end
         STEP_INS_LOOP: begin
            w.ptr_op    = PTR_DEC;
            w.rd_sel    = RD_PTR_M1;
            w.wr_sel    = WR_SHIFT_UP;
            w.stay_sel  = STAY_MORE_DOWN;
            w.next_step = STEP_INS_PUT;
         end
         STEP_INS_PUT: begin
            w.wr_sel    = WR_VALUE;
            w.cnt_op    = CNT_INC;
            w.next_step = STEP_RSP_OK;
         end
         STEP_REM_INIT: begin
            w.ptr_op    = PTR_POS1;
            w.next_step = STEP_REM_LOOP;
         end
         STEP_REM_LOOP: begin
            w.ptr_op    = PTR_INC;
            w.rd_sel    = RD_PTR;
            w.wr_sel    = WR_SHIFT_DOWN;
            w.stay_sel  = STAY_MORE_UP;
            w.next_step = STEP_REM_DONE;
         end
         STEP_REM_DONE: begin
            w.cnt_op    = CNT_DEC;
            w.next_step = STEP_RSP_OK;
         end
         STEP_SRCH_INIT: begin
            w.ptr_op    = PTR_ZERO;
            w.next_step = STEP_SRCH_LOOP;
         end
         STEP_SRCH_LOOP: begin
            w.ptr_op    = PTR_INC;
            w.rd_sel    = RD_PTR;
            w.stay_sel  = STAY_MORE_UP;
            w.jump_sel  = JMP_MATCH;
            w.target    = STEP_RSP_HIT;
            w.next_step = STEP_RSP_MISS;
         end
         STEP_RSP_OK: begin
            w.stay_sel   = STAY_RSP_BUSY;
            w.rsp_load   = 1'b1;
            w.rsp_status = ST_OK;
         end
         STEP_RSP_HIT: begin
            w.stay_sel   = STAY_RSP_BUSY;
            w.rsp_load   = 1'b1;
            w.rsp_status = ST_OK;
            w.rsp_hit    = 1'b1;
         end
         STEP_RSP_MISS: begin
            w.stay_sel   = STAY_RSP_BUSY;
            w.rsp_load   = 1'b1;
            w.rsp_status = ST_NOT_FOUND;
         end
         STEP_RSP_BAD: begin
            w.stay_sel   = STAY_RSP_BUSY;
            w.rsp_load   = 1'b1;
            w.rsp_status = ST_BAD_POS;
         end
         STEP_RSP_FULL: begin
            w.stay_sel   = STAY_RSP_BUSY;
            w.rsp_load   = 1'b1;
            w.rsp_status = ST_FULL;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/oale_seq.sv -----
// Microcoded sequencer of the list engine: step counter, control table, jumps.
// Depends on oale_pkg for the step codes, the control word and the ucode table.
`default_nettype none

module oale_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire oale_pkg::seq_cond_type cond,
   output oale_pkg::seq_ctrl_type      ctrl
);

   oale_pkg::step_type  step_ff;
   oale_pkg::step_type  step_in;
   oale_pkg::ucode_type word;
   oale_pkg::step_type  dispatch_target;
   oale_pkg::step_type  jump_target;
   logic                stay;
   logic                taken;
   logic                act;

   // Fetch the control word of the current step
   always_comb begin
      word = oale_pkg::ucode_rom(step_ff);
   end

   // Pick the handler for the captured request
   always_comb begin
      case (cond.kind)
         oale_pkg::KIND_INSERT: begin
            if (cond.pos_gt_count) begin
               dispatch_target = oale_pkg::STEP_RSP_BAD;
            end else if (cond.full) begin
               dispatch_target = oale_pkg::STEP_RSP_FULL;
            end else begin
               dispatch_target = oale_pkg::STEP_INS_INIT;
            end
         end
         oale_pkg::KIND_REMOVE: begin
            dispatch_target = cond.pos_ge_count ? oale_pkg::STEP_RSP_BAD
                                                : oale_pkg::STEP_REM_INIT;
         end
         oale_pkg::KIND_SEARCH: begin
            dispatch_target = oale_pkg::STEP_SRCH_INIT;
         end
         default: begin
            dispatch_target = oale_pkg::STEP_RSP_BAD;
         end
      endcase
   end

   // Evaluate stay and jump conditions
   always_comb begin
      case (word.stay_sel)
         oale_pkg::STAY_NO_REQ:    stay = !cond.req_valid;
         oale_pkg::STAY_MORE_DOWN: stay = cond.more_down;
         oale_pkg::STAY_MORE_UP:   stay = cond.more_up;
         oale_pkg::STAY_RSP_BUSY:  stay = cond.rsp_busy;
         default:                  stay = 1'b0;
      endcase
      case (word.jump_sel)
         oale_pkg::JMP_MATCH: begin
            taken       = cond.match;
            jump_target = word.target;
         end
         oale_pkg::JMP_DISPATCH: begin
            taken       = 1'b1;
            jump_target = dispatch_target;
         end
         default: begin
            taken       = 1'b0;
            jump_target = word.target;
         end
      endcase
   end

   // Next step: jump, hold, or fall through
   always_comb begin
      if (taken) begin
         step_in = jump_target;
      end else if (stay) begin
         step_in = step_ff;
      end else begin
         step_in = word.next_step;
      end
   end

   // Gate the control word (take and write select pass ungated): loop steps act while staying, others once leaving
   always_comb begin
      if (word.stay_sel inside {oale_pkg::STAY_MORE_DOWN, oale_pkg::STAY_MORE_UP}) begin
         act = !taken && stay;
      end else begin
         act = !taken && !stay;
      end
      ctrl.req_ready  = word.req_take;
      ctrl.ptr_op     = act ? word.ptr_op : oale_pkg::PTR_HOLD;
      ctrl.rd_sel     = act ? word.rd_sel : oale_pkg::RD_NONE;
      ctrl.wr_sel     = word.wr_sel;
      ctrl.cnt_op     = act ? word.cnt_op : oale_pkg::CNT_HOLD;
      ctrl.rsp_load   = word.rsp_load && act;
      ctrl.rsp_status = word.rsp_status;
      ctrl.rsp_hit    = word.rsp_hit;
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= oale_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ordered_array_list_engine.sv -----
// Ordered array list engine: packed list of signed 32-bit values with insert,
// remove and linear search requests. One request is worked at a time by a
// microcoded sequencer over an entry RAM with one read and one write port that
// moves or compares one entry per cycle. The time from acceptance to a valid
// result grows with the entries that the walk over the RAM read port passes:
// from the count down to the position for an insert, from the position up to
// the count for a remove, and up to the hit or the count for a search. Out-of-
// range and full requests answer without a walk. The sequencer then returns to
// its idle step, where it takes the next request. A finished result waits in an
// output register, and the next request is taken while it waits. No clearing
// pass is needed after reset; entries are only read below the count.
// Depends on oale_pkg, oale_seq and ordered_array_list_engine_defines.svh.
`default_nettype none
`include "ordered_array_list_engine_defines.svh"

module ordered_array_list_engine #(
   parameter int DEPTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic [5:0]         req_position,
   input  wire logic signed [31:0] req_item_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [4:0]              rsp_found_index,
   output logic [5:0]              rsp_entry_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;

   oale_pkg::seq_cond_type cond;
   oale_pkg::seq_ctrl_type ctrl;

   logic [1:0]         kind_ff, kind_in;
   logic [5:0]         pos_ff, pos_in;
   logic signed [31:0] val_ff, val_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CMPW-1:0]    ptr_ff, ptr_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   logic signed [31:0] rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_index_ff, rsp_index_in;
   logic [5:0]         rsp_count_ff, rsp_count_in;

   logic signed [31:0] mem [DEPTH];
   logic               rd_en;
   logic               mem_we;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [CMPW-1:0]    pos_ext;
   logic [CMPW-1:0]    count_ext;
   logic               accept;

   oale_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   // Flags for the sequencer
   always_comb begin
      pos_ext           = CMPW'(pos_ff);
      count_ext         = CMPW'(count_ff);
      cond.req_valid    = req_valid;
      cond.more_down    = ptr_ff > pos_ext;
      cond.more_up      = ptr_ff < count_ext;
      cond.rsp_busy     = rsp_valid_ff && !rsp_ready;
      cond.match        = rd_valid_ff && (rd_data_ff == val_ff);
      cond.kind         = kind_ff;
      cond.pos_gt_count = pos_ext > count_ext;
      cond.pos_ge_count = pos_ext >= count_ext;
      cond.full         = count_ff == CW'(DEPTH);
   end

   // Capture the request
   assign req_ready = ctrl.req_ready;
   assign accept    = req_valid && ctrl.req_ready;

   always_comb begin
      kind_in = accept ? req_kind       : kind_ff;
      pos_in  = accept ? req_position   : pos_ff;
      val_in  = accept ? req_item_value : val_ff;
   end

   // Walk pointer
   always_comb begin
      case (ctrl.ptr_op)
         oale_pkg::PTR_COUNT: ptr_in = count_ext;
         oale_pkg::PTR_POS1:  ptr_in = pos_ext + CMPW'(1);
         oale_pkg::PTR_ZERO:  ptr_in = '0;
         oale_pkg::PTR_INC:   ptr_in = ptr_ff + CMPW'(1);
         oale_pkg::PTR_DEC:   ptr_in = ptr_ff - CMPW'(1);
         default:             ptr_in = ptr_ff;
      endcase
   end

   // Read port select
   always_comb begin
      case (ctrl.rd_sel)
         oale_pkg::RD_PTR: begin
            rd_en      = 1'b1;
            rd_addr_in = AW'(ptr_ff);
         end
         oale_pkg::RD_PTR_M1: begin
            rd_en      = 1'b1;
            rd_addr_in = AW'(ptr_ff - CMPW'(1));
         end
         default: begin
            rd_en      = 1'b0;
            rd_addr_in = rd_addr_ff;
         end
      endcase
      rd_valid_in = rd_en;
   end

   // Write port: shift the entry read last cycle, or drop in the new value
   always_comb begin
      case (ctrl.wr_sel)
         oale_pkg::WR_SHIFT_UP: begin
            mem_we  = rd_valid_ff;
            wr_addr = rd_addr_ff + AW'(1);
            wr_data = rd_data_ff;
         end
         oale_pkg::WR_SHIFT_DOWN: begin
            mem_we  = rd_valid_ff;
            wr_addr = rd_addr_ff - AW'(1);
            wr_data = rd_data_ff;
         end
         oale_pkg::WR_VALUE: begin
            mem_we  = 1'b1;
            wr_addr = AW'(pos_ext);
            wr_data = val_ff;
         end
         default: begin
            mem_we  = 1'b0;
            wr_addr = rd_addr_ff;
            wr_data = rd_data_ff;
         end
      endcase
   end

   // Entry count
   always_comb begin
      case (ctrl.cnt_op)
         oale_pkg::CNT_INC: count_in = count_ff + CW'(1);
         oale_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:           count_in = count_ff;
      endcase
   end

   // Result register: load when free, drop once taken
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (ctrl.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ctrl.rsp_status;
         rsp_index_in  = ctrl.rsp_hit ? 5'(rd_addr_ff) : 5'd0;
         rsp_count_in  = 6'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Entry RAM with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_in];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      ptr_ff        <= ptr_in;
      rd_addr_ff    <= rd_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Checks
   `OALE_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `OALE_ASSERT_NEXT(a_count_step, clock, reset, ctrl.cnt_op == oale_pkg::CNT_HOLD, $stable(count_ff))
   `OALE_ASSERT_IMPL(a_rsp_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !ctrl.rsp_load)
   `OALE_ASSERT_IMPL(a_idle_quiet, clock, reset, ctrl.req_ready, !mem_we && !rd_en)

endmodule

`default_nettype wire

// ----- sim/list_check_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the ordered array list engine bench: a mirror of the list
// that predicts each response, and the queue of responses still owed.
// Depends on oale_pkg for the request kinds and status codes.
package list_check_pkg;

   localparam int LIST_DEPTH = 32;
   // Kind code the block does not define; it must answer bad position
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      oale_pkg::status_type status;
      logic [4:0]           found_index;
      logic [5:0]           entry_count;
   } list_rsp_type;

   class list_scoreboard;
      logic signed [31:0] mirror [LIST_DEPTH];
      int unsigned        mirror_count;
      list_rsp_type       owed_q [$];
      int unsigned        error_count;

      function new();
         foreach (mirror[i]) mirror[i] = '0;
         mirror_count = 0;
         error_count  = 0;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      // Apply an accepted request to the mirror and queue the response it owes
      function void note_request(logic [1:0] kind, logic [5:0] position,
                                 logic signed [31:0] item_value);
         list_rsp_type rsp;
         int unsigned  i;
         bit           hit;
         rsp.status      = oale_pkg::ST_OK;
         rsp.found_index = '0;
         hit             = 1'b0;
         case (kind)
            oale_pkg::KIND_INSERT: begin
               // range check comes before the full check
               if (position > mirror_count) begin
                  rsp.status = oale_pkg::ST_BAD_POS;
               end else if (mirror_count >= LIST_DEPTH) begin
                  rsp.status = oale_pkg::ST_FULL;
               end else begin
                  for (i = mirror_count; i > position; i--) mirror[i] = mirror[i - 1];
                  mirror[position] = item_value;
                  mirror_count++;
               end
            end
            oale_pkg::KIND_REMOVE: begin
               if (position >= mirror_count) begin
                  rsp.status = oale_pkg::ST_BAD_POS;
               end else begin
                  for (i = position; i + 1 < mirror_count; i++) mirror[i] = mirror[i + 1];
                  mirror_count--;
               end
            end
            oale_pkg::KIND_SEARCH: begin
               // lowest matching index wins
               rsp.status = oale_pkg::ST_NOT_FOUND;
               for (i = 0; i < mirror_count && !hit; i++) begin
                  if (mirror[i] == item_value) begin
                     hit             = 1'b1;
                     rsp.status      = oale_pkg::ST_OK;
                     rsp.found_index = i[4:0];
                  end
               end
            end
            default: begin
               rsp.status = oale_pkg::ST_BAD_POS;
            end
         endcase
         rsp.entry_count = mirror_count[5:0];
         owed_q.push_back(rsp);
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         error_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      endfunction

      // Compare a response with the oldest one owed
      function void check_response(logic [1:0] status, logic [4:0] found_index,
                                   logic [5:0] entry_count);
         list_rsp_type want;
         if (owed_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response: expected none, actual status %0h",
                     $time, status);
            return;
         end
         want = owed_q.pop_front();
         if (want.status !== status) flag("status", want.status, status);
         if (want.found_index !== found_index)
            flag("found_index", want.found_index, found_index);
         if (want.entry_count !== entry_count)
            flag("entry_count", want.entry_count, entry_count);
      endfunction
   endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the ordered array list engine bench: clock, reset, request and
// response drivers, directed and random traffic. Depends on oale_pkg,
// list_check_pkg and the ordered_array_list_engine RTL.
module tb_top;

   localparam int unsigned RANDOM_REQUESTS = 2000;
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES    = 100;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic [1:0]         req_kind       = oale_pkg::KIND_INSERT;
   logic [5:0]         req_position   = '0;
   logic signed [31:0] req_item_value = '0;
   logic               rsp_ready      = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_found_index;
   logic [5:0]         rsp_entry_count;

   list_check_pkg::list_scoreboard sb;
   bit             no_idle         = 1'b0;
   int unsigned    rsp_hold_cycles = 0;
   int unsigned    requests_sent   = 0;
   int unsigned    quiet_cycles    = 0;

   ordered_array_list_engine #(.DEPTH(list_check_pkg::LIST_DEPTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // End the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input logic [1:0] kind, input logic [5:0] position,
                               input logic signed [31:0] item_value);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_position   <= position;
      req_item_value <= item_value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, position, item_value);
      requests_sent++;
   endtask

   // Drop the request line and wait until every owed response is back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Mix of random, small (to make duplicates), extreme and stored values
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return int'($urandom_range(0, 8)) - 4;
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return (sb.mirror_count != 0) ?
                         sb.mirror[$urandom_range(0, sb.mirror_count - 1)] : $urandom;
      endcase
   endfunction

   // Response side: random stalls, plus one long hold-off on request
   initial begin : response_sink
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_status, rsp_found_index, rsp_entry_count);
      end
   end

   initial begin : stimulus
      int unsigned seq_num;
      int unsigned seq_len;
      int unsigned pos;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list: search miss, remove from empty, insert past end, unused kind
      send_request(oale_pkg::KIND_SEARCH, 6'd63, 32'sd0);
      send_request(oale_pkg::KIND_REMOVE, 6'd0, 32'sd0);
      send_request(oale_pkg::KIND_INSERT, 6'd1, 32'sd7);
      send_request(list_check_pkg::KIND_UNUSED, 6'd63, 32'shFFFF_FFFF);
      // Build a short list with extremes at front and middle, append at the end, then insert past it
      send_request(oale_pkg::KIND_INSERT, 6'd0, 32'sh7FFF_FFFF);
      send_request(oale_pkg::KIND_INSERT, 6'd0, 32'sh8000_0000);
      send_request(oale_pkg::KIND_INSERT, 6'd2, 32'sd0);
      send_request(oale_pkg::KIND_INSERT, 6'd1, -32'sd1);
      send_request(oale_pkg::KIND_INSERT, 6'(sb.mirror_count), 32'sd1);
      send_request(oale_pkg::KIND_INSERT, 6'(sb.mirror_count + 1), 32'sd5);
      send_request(oale_pkg::KIND_INSERT, 6'd63, 32'sd5);
      // Hits at first, last and middle, then a miss
      send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'sh8000_0000);
      send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'sd1);
      send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'sh7FFF_FFFF);
      send_request(oale_pkg::KIND_SEARCH, 6'd0, 32'sd12345);
      // Duplicate value: first match must win
      send_request(oale_pkg::KIND_INSERT, 6'd0, -32'sd1);
      send_request(oale_pkg::KIND_SEARCH, 6'd0, -32'sd1);
      // Remove past the end, then last, first and middle entries
      send_request(oale_pkg::KIND_REMOVE, 6'(sb.mirror_count), 32'sd0);
      send_request(oale_pkg::KIND_REMOVE, 6'd63, 32'sd0);
      send_request(oale_pkg::KIND_REMOVE, 6'(sb.mirror_count - 1), 32'sd0);
      send_request(oale_pkg::KIND_REMOVE, 6'd0, 32'sd0);
      send_request(oale_pkg::KIND_REMOVE, 6'd1, 32'sd0);
      send_request(list_check_pkg::KIND_UNUSED, 6'd0, 32'sd0);

      seq_num = 0;
      while (requests_sent < RANDOM_REQUESTS + 23) begin
         no_idle = ($urandom_range(0, 3) == 0);
         // Hold off responses so the block backs up into its request side
         if (seq_num % 8 == 1) rsp_hold_cycles = 300 + $urandom_range(0, 200);
         // Let the block go completely idle
         if (seq_num % 8 == 5) pause_until_drained();
         case ($urandom_range(0, 9))
            0, 1: begin
               // Fill to capacity, then knock on the full list
               while (sb.mirror_count < list_check_pkg::LIST_DEPTH)
                  send_request(oale_pkg::KIND_INSERT,
                               6'($urandom_range(0, sb.mirror_count)), pick_value());
               repeat ($urandom_range(1, 3))
                  send_request(oale_pkg::KIND_INSERT,
                               6'($urandom_range(0, list_check_pkg::LIST_DEPTH)),
                               pick_value());
            end
            2, 3: begin
               // Drain to empty, then remove from the empty list
               while (sb.mirror_count != 0)
                  send_request(oale_pkg::KIND_REMOVE,
                               6'($urandom_range(0, sb.mirror_count - 1)), pick_value());
               repeat ($urandom_range(1, 2))
                  send_request(oale_pkg::KIND_REMOVE, 6'($urandom_range(0, 63)), $urandom);
            end
            4, 5, 6, 7: begin
               // Mostly legal traffic with random content
               seq_len = $urandom_range(10, 40);
               repeat (seq_len) begin
                  case ($urandom_range(0, 2))
                     0: begin
                        pos = ($urandom_range(0, 7) == 0) ? sb.mirror_count + 1 :
                              $urandom_range(0, sb.mirror_count);
                        send_request(oale_pkg::KIND_INSERT, 6'(pos), pick_value());
                     end
                     1: begin
                        pos = (sb.mirror_count == 0) ? 0 :
                              $urandom_range(0, sb.mirror_count - 1);
                        send_request(oale_pkg::KIND_REMOVE, 6'(pos), pick_value());
                     end
                     default: begin
                        send_request(oale_pkg::KIND_SEARCH, 6'($urandom_range(0, 63)),
                                     pick_value());
                     end
                  endcase
               end
            end
            default: begin
               // Noise: any kind, any position, any value
               seq_len = $urandom_range(5, 15);
               repeat (seq_len)
                  send_request(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), $urandom);
            end
         endcase
         seq_num++;
      end

      // Wait out every owed response, then a margin for strays
      no_idle = 1'b0;
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
